[rtl/fbba_pkg.sv]
`timescale 1ns / 1ps

package fbba_pkg;

    // Transform size and derived limits
    localparam int FFT_POINTS = 512;
    localparam int NUM_BANDS  = 32;

    localparam int BIN_W    = 8;
    localparam int MAG_W    = 16;
    localparam int RATE_W   = 18;
    localparam int LEVEL_W  = 16;
    localparam int BAND_W   = 5;
    localparam int SCALED_W = BIN_W + RATE_W;

    // Widest band edge times transform size sets the compare width
    localparam int TOP_HZ   = 20000;
    localparam int THR_W    = $clog2(TOP_HZ * FFT_POINTS + 1);
    localparam int CMP_W    = (THR_W > SCALED_W) ? THR_W : SCALED_W;

    localparam logic [LEVEL_W:0]   LEVEL_ONE   = (LEVEL_W + 1)'(32768);
    localparam logic [RATE_W-1:0]  RATE_RESET  = RATE_W'(44100);
    localparam logic [BAND_W-1:0]  LAST_BAND   = BAND_W'(NUM_BANDS - 1);

    // Upper band edges in hertz, inclusive at the top
    localparam int BAND_TOP_HZ [NUM_BANDS-1] = '{
        43, 86, 129, 172, 215, 258, 301, 344, 388, 431, 474, 517, 560, 603,
        646, 689, 800, 1000, 1250, 1600, 2000, 2500, 3150, 4000, 5000, 6300,
        8000, 10000, 12500, 16000, TOP_HZ
    };

    // Band choice for one bin
    typedef struct packed {
        logic              hit;
        logic [BAND_W-1:0] band;
    } band_sel_t;

endpackage

[rtl/fbba_ram.sv]
`timescale 1ns / 1ps

module fbba_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[rtl/fbba_band_map.sv]
`timescale 1ns / 1ps

module fbba_band_map
    import fbba_pkg::*;
(
    input  logic [SCALED_W-1:0] scaled,
    input  logic [BIN_W-1:0]    bin,
    output band_sel_t           sel
);

    logic [CMP_W-1:0] scaled_ext;
    logic             above_nyq;

    assign scaled_ext = CMP_W'(scaled);
    assign above_nyq  = ((32'(bin) << 1) >= 32'(FFT_POINTS));

    // Count the band edges the bin lies above; edges rise, so the last one wins
    always_comb
    begin
        sel.band = '0;
        for (int k = 0; k < NUM_BANDS - 1; k++)
        begin
            if (scaled_ext > CMP_W'(BAND_TOP_HZ[k] * FFT_POINTS))
            begin
                sel.band = BAND_W'(k + 1);
            end
        end
        // Drop zero frequency and bins at or above half the sample rate
        sel.hit = (scaled != '0) && !above_nyq;
    end

endmodule

[rtl/fft_bin_band_accumulator.sv]
`timescale 1ns / 1ps

// Sorts FFT bins into 32 fixed audio bands and accumulates each band's Q1.15
// magnitude, saturating at 1.0. The band levels live in a 32-entry RAM with a
// registered read, so every bin is a read-modify-write of one entry: a bin is
// taken, mapped to its band (product of bin and sample rate against the band
// edges) and written back before the next bin is taken. A bin marked last_bin
// then starts a pass over the RAM to find the peak band, followed by the 32
// band results in order, each read and then loaded once the output register
// is free; each band is cleared as its result is loaded. New bins are taken
// again as soon as the band 31 result sits in the output register. sample_rate
// may be written at any time the block is idle; bins that map to 0 Hz or to
// half the sample rate and above add nothing.
module fft_bin_band_accumulator
    import fbba_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    // Configuration
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [RATE_W-1:0]  sample_rate,
    // Bin input
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [BIN_W-1:0]   bin_index,
    input  logic [MAG_W-1:0]   magnitude,
    input  logic               last_bin,
    // Band results
    output logic               out_valid,
    input  logic               out_ready,
    output logic [BAND_W-1:0]  band_index,
    output logic [LEVEL_W-1:0] band_level,
    output logic [BAND_W-1:0]  peak_band,
    output logic [LEVEL_W-1:0] peak_level,
    output logic               last_band
);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_MAP      = 3'd1;
    localparam logic [2:0] S_UPD      = 3'd2;
    localparam logic [2:0] S_SCAN     = 3'd3;
    localparam logic [2:0] S_SCAN_END = 3'd4;
    localparam logic [2:0] S_EMIT_RD  = 3'd5;
    localparam logic [2:0] S_EMIT_LD  = 3'd6;

    logic [2:0]           state_reg, state_next;
    logic [BAND_W-1:0]    idx_reg, idx_next;
    logic [RATE_W-1:0]    rate_reg;
    logic [SCALED_W-1:0]  scaled_reg;
    logic [BIN_W-1:0]     bin_reg;
    logic [MAG_W-1:0]     mag_reg;
    logic                 last_reg;
    band_sel_t            sel;
    band_sel_t            sel_reg;
    logic [NUM_BANDS-1:0] lvl_vld_reg;
    logic                 rvld_reg;
    logic                 cmp_vld_reg;
    logic [BAND_W-1:0]    cmp_idx_reg;
    logic [BAND_W-1:0]    pk_band_reg;
    logic [LEVEL_W-1:0]   pk_level_reg;
    logic                 out_valid_reg;
    logic [BAND_W-1:0]    out_band_reg;
    logic [LEVEL_W-1:0]   out_level_reg;
    logic [BAND_W-1:0]    out_pk_band_reg;
    logic [LEVEL_W-1:0]   out_pk_level_reg;
    logic                 out_last_reg;

    logic                 in_fire;
    logic                 out_fire;
    logic                 emit_go;
    logic                 ram_we;
    logic                 ram_re;
    logic [BAND_W-1:0]    ram_raddr;
    logic [LEVEL_W-1:0]   ram_rdata;
    logic [LEVEL_W-1:0]   level;
    logic [LEVEL_W:0]     sum;
    logic [LEVEL_W-1:0]   sum_sat;

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == S_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign out_fire  = out_valid_reg && out_ready;
    assign emit_go   = !out_valid_reg || out_ready;

    // Band edge compare on the registered product
    fbba_band_map u_band_map (
        .scaled (scaled_reg),
        .bin    (bin_reg),
        .sel    (sel)
    );

    // Band level store
    fbba_ram #(
        .WIDTH (LEVEL_W),
        .DEPTH (NUM_BANDS)
    ) u_level_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (sel_reg.band),
        .wdata (sum_sat),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // An entry never written since its last clear reads as zero
    assign level   = rvld_reg ? ram_rdata : '0;
    assign sum     = (LEVEL_W + 1)'(level) + (LEVEL_W + 1)'(mag_reg);
    assign sum_sat = (sum > LEVEL_ONE) ? LEVEL_W'(LEVEL_ONE) : sum[LEVEL_W-1:0];
    assign ram_we  = (state_reg == S_UPD) && sel_reg.hit;

    // Select read address by phase
    always_comb
    begin
        ram_re    = 1'b0;
        ram_raddr = idx_reg;
        unique case (state_reg)
            S_MAP:
            begin
                ram_re    = 1'b1;
                ram_raddr = sel.band;
            end
            S_SCAN:
            begin
                ram_re = 1'b1;
            end
            S_EMIT_RD:
            begin
                ram_re = emit_go;
            end
            default:
            begin
                ram_re = 1'b0;
            end
        endcase
    end

    // Sequence one bin, then the frame-end scan and readout
    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = S_MAP;
                end
            end
            S_MAP:
            begin
                state_next = S_UPD;
            end
            S_UPD:
            begin
                idx_next   = '0;
                state_next = last_reg ? S_SCAN : S_IDLE;
            end
            S_SCAN:
            begin
                idx_next = idx_reg + 1'b1;
                if (idx_reg == LAST_BAND)
                begin
                    state_next = S_SCAN_END;
                end
            end
            S_SCAN_END:
            begin
                state_next = S_EMIT_RD;
            end
            S_EMIT_RD:
            begin
                if (emit_go)
                begin
                    state_next = S_EMIT_LD;
                end
            end
            S_EMIT_LD:
            begin
                idx_next   = idx_reg + 1'b1;
                state_next = (idx_reg == LAST_BAND) ? S_IDLE : S_EMIT_RD;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            idx_reg       <= '0;
            rate_reg      <= RATE_RESET;
            lvl_vld_reg   <= '0;
            cmp_vld_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            pk_band_reg   <= '0;
            pk_level_reg  <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            cmp_vld_reg <= (state_reg == S_SCAN);

            if (cfg_valid && cfg_ready)
            begin
                rate_reg <= sample_rate;
            end

            // Mark a band as holding data once written, clear it on readout
            if (ram_we)
            begin
                lvl_vld_reg[sel_reg.band] <= 1'b1;
            end
            if (state_reg == S_EMIT_LD)
            begin
                lvl_vld_reg[idx_reg] <= 1'b0;
            end

            // Restart the peak at frame end, keep the first strict maximum
            if ((state_reg == S_UPD) && last_reg)
            begin
                pk_band_reg  <= '0;
                pk_level_reg <= '0;
            end
            else if (cmp_vld_reg && (level > pk_level_reg))
            begin
                pk_band_reg  <= cmp_idx_reg;
                pk_level_reg <= level;
            end

            // Hold a result until its transaction completes
            if (state_reg == S_EMIT_LD)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_fire)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            bin_reg    <= bin_index;
            mag_reg    <= magnitude;
            last_reg   <= last_bin;
            scaled_reg <= SCALED_W'(bin_index) * SCALED_W'(rate_reg);
        end
        if (state_reg == S_MAP)
        begin
            sel_reg <= sel;
        end
        if (ram_re)
        begin
            rvld_reg <= lvl_vld_reg[ram_raddr];
        end
        cmp_idx_reg <= idx_reg;
        if (state_reg == S_EMIT_LD)
        begin
            out_band_reg     <= idx_reg;
            out_level_reg    <= level;
            out_pk_band_reg  <= pk_band_reg;
            out_pk_level_reg <= pk_level_reg;
            out_last_reg     <= (idx_reg == LAST_BAND);
        end
    end

    assign out_valid  = out_valid_reg;
    assign band_index = out_band_reg;
    assign band_level = out_level_reg;
    assign peak_band  = out_pk_band_reg;
    assign peak_level = out_pk_level_reg;
    assign last_band  = out_last_reg;

    // Levels never pass 1.0 and never exceed the frame peak
    a_level_sat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((band_level <= LEVEL_W'(LEVEL_ONE)) && (peak_level >= band_level)))
        else $error("band level above saturation or above peak");

    // The end-of-run flag marks band 31 only
    a_last_band: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (last_band == (band_index == LAST_BAND)))
        else $error("last_band flag on wrong band");

    // A result is loaded only into a free output register
    a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT_LD) |-> !out_valid_reg)
        else $error("result loaded over a pending transaction");

    // The band count advances after every readout step
    a_emit_seq: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT_LD) |=> (idx_reg == $past(idx_reg) + 1'b1))
        else $error("readout index did not advance");

endmodule
